// File: design/dtie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtie_pkg: shared types and constants
// Request and result payloads plus the character codes that the decimal
// text converter recognizes.
// ----------------------------------------------------------------------------
package dtie_pkg;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_E_LO  = 8'h65;
	localparam logic [7:0] CHAR_E_UP  = 8'h45;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int MANT_W = 64;
	localparam int EXP_W  = 32;

	typedef struct packed {
		logic [7:0] character;
		logic       exponent_enabled;
		logic       last_character;
	} req_t;

	typedef struct packed {
		logic signed [MANT_W-1:0] mantissa;
		logic signed [EXP_W-1:0]  exponent_value;
		logic                     exp_present;
		logic                     overflow;
	} res_t;

endpackage

// File: design/decimal_text_to_integer_exponent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_integer_exponent: ASCII number text to mantissa/exponent
// Takes one character per request and returns one result on the last one.
// ----------------------------------------------------------------------------
// Accepts one character every cycle unless intake pauses. A request goes into
// an input register; from there the multiply-by-ten add and the sign handling
// update the running state, and for a last character the result lands in a
// two-entry output queue that presents it on the result port. Intake pauses
// only while both queue entries hold results and the registered character is
// a last one. The 64-bit multiply-by-ten add of the mantissa is the longest
// path.
module decimal_text_to_integer_exponent
	import dtie_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic request_valid,
	output logic request_ready,
	input  req_t request,
	output logic result_valid,
	input  logic result_ready,
	output res_t result
);

	// input register
	logic v_s1;
	req_t req_s1;

	// running state
	logic [MANT_W-1:0] mant_acc_q;
	logic [EXP_W-1:0]  exp_acc_q;
	logic in_exp_q, mant_neg_q, exp_neg_q, prev_marker_q, first_q, mode_q, ovf_q;

	// output queue
	logic skid_valid_q;
	res_t head_q, skid_q;

	logic advance, push;
	logic first, mode, mant_neg;
	logic is_marker, is_digit, is_minus;
	logic [MANT_W-1:0] digit;
	logic [MANT_W+3:0] mant_wide;
	logic [EXP_W+3:0]  exp_wide;
	logic [MANT_W-1:0] mant_n;
	logic [EXP_W-1:0]  exp_n;
	logic in_exp_n, exp_neg_n, marker_now, ovf_n;
	res_t res_n;

	assign advance       = v_s1 && (!req_s1.last_character || !skid_valid_q);
	assign push          = advance && req_s1.last_character;
	assign request_ready = !v_s1 || advance;

	always_comb begin
		first     = first_q;
		mode      = first_q ? req_s1.exponent_enabled : mode_q;
		mant_neg  = first_q ? (req_s1.character == CHAR_MINUS) : mant_neg_q;
		is_marker = (req_s1.character == CHAR_E_LO) || (req_s1.character == CHAR_E_UP);
		is_digit  = (req_s1.character >= CHAR_ZERO) && (req_s1.character <= CHAR_NINE);
		is_minus  = (req_s1.character == CHAR_MINUS);
		digit     = {{(MANT_W-4){1'b0}}, req_s1.character[3:0]};
		mant_wide = ({4'b0, mant_acc_q} << 3) + ({4'b0, mant_acc_q} << 1) + {4'b0, digit};
		exp_wide  = ({4'b0, exp_acc_q} << 3) + ({4'b0, exp_acc_q} << 1)
			+ {4'b0, digit[EXP_W-1:0]};

		mant_n     = mant_acc_q;
		exp_n      = exp_acc_q;
		in_exp_n   = in_exp_q;
		exp_neg_n  = exp_neg_q;
		marker_now = 1'b0;
		ovf_n      = ovf_q;

		if (is_marker) begin
			if (mode) begin
				in_exp_n   = 1'b1;
				marker_now = !first;
			end
		end else if (is_digit) begin
			if (in_exp_q) begin
				exp_n = exp_wide[EXP_W-1:0];
				if (exp_wide[EXP_W+3:EXP_W] != 4'd0) ovf_n = 1'b1;
			end else begin
				mant_n = mant_wide[MANT_W-1:0];
				if (mant_wide[MANT_W+3:MANT_W] != 4'd0) ovf_n = 1'b1;
			end
		end else if (is_minus) begin
			if (prev_marker_q) exp_neg_n = 1'b1;
		end

		res_n.mantissa       = mant_neg ? -mant_n : mant_n;
		res_n.exponent_value = !mode ? '0 : (exp_neg_n ? -exp_n : exp_n);
		res_n.exp_present    = mode;
		res_n.overflow       = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (request_ready) begin
			v_s1 <= request_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request_ready && request_valid) req_s1 <= request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mant_acc_q    <= '0;
			exp_acc_q     <= '0;
			in_exp_q      <= 1'b0;
			mant_neg_q    <= 1'b0;
			exp_neg_q     <= 1'b0;
			prev_marker_q <= 1'b0;
			first_q       <= 1'b1;
			mode_q        <= 1'b0;
			ovf_q         <= 1'b0;
		end else if (advance) begin
			if (req_s1.last_character) begin
				// back to start state for the next number
				mant_acc_q    <= '0;
				exp_acc_q     <= '0;
				in_exp_q      <= 1'b0;
				mant_neg_q    <= 1'b0;
				exp_neg_q     <= 1'b0;
				prev_marker_q <= 1'b0;
				first_q       <= 1'b1;
				mode_q        <= 1'b0;
				ovf_q         <= 1'b0;
			end else begin
				mant_acc_q    <= mant_n;
				exp_acc_q     <= exp_n;
				in_exp_q      <= in_exp_n;
				mant_neg_q    <= mant_neg;
				exp_neg_q     <= exp_neg_n;
				prev_marker_q <= marker_now;
				first_q       <= 1'b0;
				mode_q        <= mode;
				ovf_q         <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!result_valid || result_ready) begin
			if (skid_valid_q) begin
				result_valid <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				result_valid <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!result_valid || result_ready) begin
			if (skid_valid_q) head_q <= skid_q;
			else if (push) head_q <= res_n;
		end else if (push) begin
			skid_q <= res_n;
		end
	end

	assign result = head_q;

endmodule

// File: design/dtie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtie_checker: port-level checks for the decimal text converter
// Watches the request and result channels and flags broken invariants.
// ----------------------------------------------------------------------------
module dtie_checker
	import dtie_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic request_valid,
	input logic request_ready,
	input req_t request,
	input logic result_valid,
	input logic result_ready,
	input res_t result
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// intake only stalls behind pending results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!request_ready |-> result_valid)
		else $error("request stalled with no result pending");

	a_exp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.exp_present |-> result.exponent_value == '0)
		else $error("exponent nonzero with exponents disabled");

	// a new result follows its ending request via the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(request_valid && request_ready, 2))
		else $error("result without a matching request");

endmodule

bind decimal_text_to_integer_exponent dtie_checker u_dtie_checker (
	.clk(clk),
	.arst_n(arst_n),
	.request_valid(request_valid),
	.request_ready(request_ready),
	.request(request),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for decimal_text_to_integer_exponent
// Feeds JSON number text one character per request and checks each result
// against a cycle-free model of the mantissa/exponent conversion, or against
// the expected value in a short table of hand-picked strings that runs first.
// Random well-formed numbers, overflow boundaries, marker corner cases and byte
// noise follow, with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import dtie_pkg::*;

	localparam int RANDOM_CHARS  = 500;
	localparam int HOLD_OFF_CYC  = 300;
	localparam int DRAIN_CYC     = 8;

	typedef struct packed {
		req_t req;
		logic typed;
		res_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic request_valid;
	logic request_ready;
	req_t request;
	logic result_valid;
	logic result_ready;
	res_t result;

	// conversion state of the model
	logic [63:0] mag_acc;
	logic [31:0] exp_acc;
	logic        in_exp;
	logic        neg_mant;
	logic        neg_exp;
	logic        after_marker;
	logic        at_start;
	logic        exp_mode;
	logic        wrapped;

	res_t        expected_numbers[$];
	logic [7:0]  text_q[$];

	int errors = 0;
	int chars_sent;
	int numbers_sent;
	int results_checked = 0;
	int overflow_results = 0;
	int neg_exp_results = 0;
	int input_stalls = 0;
	int send_mode_left;
	logic send_quiet;
	logic hold_off_due;
	logic hold_off_done;
	res_t got;
	res_t want;

	stim_row_t directed_rows [0:24] = '{
		'{'{CHAR_ZERO + 8'd7, 1'b0, 1'b1}, 1'b1, '{64'sd7, 32'sd0, 1'b0, 1'b0}},
		'{'{CHAR_MINUS, 1'b0, 1'b1}, 1'b1, '{64'sd0, 32'sd0, 1'b0, 1'b0}},
		'{'{CHAR_E_UP, 1'b1, 1'b1}, 1'b1, '{64'sd0, 32'sd0, 1'b1, 1'b0}},
		// -12e-3
		'{'{CHAR_MINUS, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CHAR_ZERO + 8'd1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_ZERO + 8'd2, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CHAR_E_LO, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_MINUS, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_ZERO + 8'd3, 1'b1, 1'b1}, 1'b1, '{-64'sd12, -32'sd3, 1'b1, 1'b0}},
		// marker first: the minus does not negate
		'{'{CHAR_E_LO, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CHAR_MINUS, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_ZERO + 8'd5, 1'b0, 1'b1}, 1'b1, '{64'sd0, 32'sd5, 1'b1, 1'b0}},
		// marker ignored with exponents off
		'{'{CHAR_ZERO + 8'd4, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_E_LO, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CHAR_ZERO + 8'd2, 1'b1, 1'b1}, 1'b1, '{64'sd42, 32'sd0, 1'b0, 1'b0}},
		// repeated markers
		'{'{CHAR_ZERO + 8'd1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CHAR_E_UP, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_E_LO, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_MINUS, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_ZERO + 8'd2, 1'b0, 1'b1}, 1'b1, '{64'sd1, -32'sd2, 1'b1, 1'b0}},
		// byte extremes
		'{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
		'{'{8'hFF, 1'b0, 1'b1}, 1'b1, '{64'sd0, 32'sd0, 1'b1, 1'b0}},
		// neighbors of the digit range
		'{'{CHAR_ZERO - 8'd1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_NINE, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CHAR_NINE + 8'd1, 1'b1, 1'b1}, 1'b1, '{64'sd9, 32'sd0, 1'b0, 1'b0}}
	};

	string edge_texts [0:7] = '{
		"18446744073709551615", "18446744073709551616", "-9223372036854775808",
		"-18446744073709551615", "99999999999999999999999", "1e4294967295",
		"1e-4294967296", "-7E-2147483648"
	};

	decimal_text_to_integer_exponent u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.request_ready(request_ready),
		.request      (request),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic clear_number();
		mag_acc      = '0;
		exp_acc      = '0;
		in_exp       = 1'b0;
		neg_mant     = 1'b0;
		neg_exp      = 1'b0;
		after_marker = 1'b0;
		at_start     = 1'b1;
		exp_mode     = 1'b0;
		wrapped      = 1'b0;
	endtask

	// Advance the conversion by one character; done marks a finished number.
	task automatic convert_char(input req_t r, output logic done, output res_t res);
		logic        first_now;
		logic        marker_now;
		logic [7:0]  digit;
		logic [67:0] wide_m;
		logic [35:0] wide_e;
		logic [63:0] m;
		logic [31:0] e;
		first_now  = at_start;
		marker_now = 1'b0;
		done       = 1'b0;
		res        = '0;
		if (first_now) begin
			exp_mode = r.exponent_enabled;
			neg_mant = (r.character == CHAR_MINUS);
		end
		if (r.character == CHAR_E_LO || r.character == CHAR_E_UP) begin
			if (exp_mode) begin
				in_exp     = 1'b1;
				marker_now = !first_now;
			end
		end else if (r.character >= CHAR_ZERO && r.character <= CHAR_NINE) begin
			digit = r.character - CHAR_ZERO;
			if (in_exp) begin
				wide_e = {4'b0, exp_acc} * 36'd10 + {28'b0, digit};
				if (wide_e[35:32] != '0)
					wrapped = 1'b1;
				exp_acc = wide_e[31:0];
			end else begin
				wide_m = {4'b0, mag_acc} * 68'd10 + {60'b0, digit};
				if (wide_m[67:64] != '0)
					wrapped = 1'b1;
				mag_acc = wide_m[63:0];
			end
		end else if (r.character == CHAR_MINUS) begin
			if (after_marker)
				neg_exp = 1'b1;
		end
		after_marker = marker_now;
		at_start     = 1'b0;
		if (r.last_character) begin
			m = neg_mant ? -mag_acc : mag_acc;
			e = neg_exp ? -exp_acc : exp_acc;
			if (!exp_mode)
				e = '0;
			res.mantissa       = m;
			res.exponent_value = e;
			res.exp_present    = exp_mode;
			res.overflow       = wrapped;
			done = 1'b1;
			clear_number();
		end
	endtask

	// Offer one request, hold it until taken, then predict its result.
	task automatic offer_char(input req_t r, input logic typed, input res_t typed_res);
		int   gap;
		logic done;
		res_t predicted;
		if (send_mode_left == 0) begin
			send_quiet     = ($urandom_range(0, 3) == 0);
			send_mode_left = $urandom_range(10, 40);
		end
		send_mode_left--;
		gap = send_quiet ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			request_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request_valid <= 1'b1;
		request       <= r;
		@(posedge clk);
		while (!request_ready) @(posedge clk);
		chars_sent++;
		convert_char(r, done, predicted);
		if (done) begin
			numbers_sent++;
			expected_numbers.push_back(typed ? typed_res : predicted);
		end
	endtask

	task automatic push_digits(input int n);
		for (int i = 0; i < n; i++)
			text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic push_marker();
		text_q.push_back($urandom_range(0, 1) ? CHAR_E_LO : CHAR_E_UP);
	endtask

	// Send the queued text as one number; en counts only on the first character.
	task automatic send_text(input logic en);
		req_t r;
		for (int i = 0; i < text_q.size(); i++) begin
			r.character        = text_q[i];
			r.exponent_enabled = (i == 0) ? en : 1'($urandom_range(0, 1));
			r.last_character   = (i == text_q.size() - 1);
			offer_char(r, 1'b0, '0);
		end
		text_q.delete();
	endtask

	task automatic compare(input string field, input logic signed [63:0] exp_v,
			input logic signed [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (request_valid && !request_ready)
				input_stalls++;
			if (result_valid && result_ready) begin
				got = result;
				if (expected_numbers.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, mantissa %0d exponent %0d",
						$time, got.mantissa, got.exponent_value);
				end else begin
					want = expected_numbers.pop_front();
					results_checked++;
					if (want.overflow)
						overflow_results++;
					if (want.exponent_value < 0)
						neg_exp_results++;
					compare("mantissa", want.mantissa, got.mantissa);
					compare("exponent_value", want.exponent_value, got.exponent_value);
					compare("exp_present", want.exp_present, got.exp_present);
					compare("overflow", want.overflow, got.overflow);
				end
			end
		end
	end

	// result side: random stalls, quiet stretches, one long hold-off
	initial begin
		int stall;
		int quiet_left;
		logic quiet;
		result_ready  = 1'b0;
		quiet_left    = 0;
		quiet         = 1'b0;
		hold_off_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_due && !hold_off_done) begin
				hold_off_done = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYC) @(negedge clk);
			end
			if (quiet_left == 0) begin
				quiet      = ($urandom_range(0, 3) == 0);
				quiet_left = $urandom_range(5, 20);
			end
			quiet_left--;
			stall = quiet ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", expected_numbers.size());
		$display("** decimal_text_to_integer_exponent: FAILED **");
		$finish;
	end

	initial begin
		int kind;
		int random_chars;
		logic en;
		arst_n           = 1'b0;
		request_valid    = 1'b0;
		request          = '0;
		chars_sent       = 0;
		numbers_sent     = 0;
		send_mode_left   = 0;
		send_quiet       = 1'b0;
		hold_off_due     = 1'b0;
		clear_number();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			offer_char(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

		random_chars = 0;
		while (random_chars < RANDOM_CHARS) begin
			if (random_chars >= 150)
				hold_off_due = 1'b1;
			kind = $urandom_range(0, 99);
			en   = 1'($urandom_range(0, 1));
			if (kind < 60) begin
				// well-formed number, mostly short, now and then near the wrap point
				if ($urandom_range(0, 2) == 0)
					text_q.push_back(CHAR_MINUS);
				push_digits(($urandom_range(0, 11) == 0) ? $urandom_range(17, 22)
					: $urandom_range(1, 6));
				if (en && $urandom_range(0, 9) != 0) begin
					push_marker();
					case ($urandom_range(0, 9))
						0, 1, 2, 3: text_q.push_back(CHAR_MINUS);
						4:          text_q.push_back("+");
						default:    ;
					endcase
					push_digits(($urandom_range(0, 11) == 0) ? $urandom_range(9, 12)
						: $urandom_range(1, 3));
				end
			end else if (kind < 70) begin
				for (int j = 0; j < edge_texts[kind % 8].len(); j++)
					text_q.push_back(edge_texts[kind % 8][j]);
			end else if (kind < 80) begin
				// markers first, doubled, or followed by stray minus signs
				en = ($urandom_range(0, 3) != 0);
				for (int k = $urandom_range(1, 5); k > 0; k--) begin
					case ($urandom_range(0, 2))
						0:       push_marker();
						1:       text_q.push_back(CHAR_MINUS);
						default: push_digits($urandom_range(1, 3));
					endcase
				end
			end else begin
				for (int k = $urandom_range(1, 8); k > 0; k--) begin
					if ($urandom_range(0, 1))
						text_q.push_back(8'($urandom_range(0, 255)));
					else
						case ($urandom_range(0, 4))
							0:       text_q.push_back(CHAR_MINUS);
							1:       push_marker();
							2:       text_q.push_back(".");
							default: push_digits(1);
						endcase
				end
			end
			random_chars += text_q.size();
			send_text(en);
		end
		@(negedge clk);
		request_valid <= 1'b0;

		while (expected_numbers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("ran %0d chars as %0d numbers; %0d checked, %0d wrapped, %0d negative exp",
			chars_sent, numbers_sent, results_checked, overflow_results, neg_exp_results);
		$display("result side held off %0d cycles once; request side stalled for %0d cycles",
			HOLD_OFF_CYC, input_stalls);
		if (errors == 0)
			$display("** decimal_text_to_integer_exponent: PASSED **");
		else
			$display("** decimal_text_to_integer_exponent: FAILED **");
		$finish;
	end

endmodule
